// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the integer parser RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define S2I_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define S2I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/s2i_pkg.sv =====
// ---------------------------------------------------------------------------
// s2i_pkg
// Shared constants, result type and character helpers for the parser
// ---------------------------------------------------------------------------
package s2i_pkg;

  localparam int unsigned INDEX_WIDTH_DEF = 16;
  localparam int unsigned VALUE_W         = 64;
  localparam int unsigned END_W           = 16;
  localparam int unsigned BASE_W          = 6;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned CFG_ADDR_W      = 3;

  // register index, taken from the word address
  localparam logic [0:0] REG_NUMBER_BASE = 1'b0;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] MAX_RADIX  = 6'd36;
  localparam logic [BASE_W-1:0] NO_DIGIT   = 6'd63;
  localparam logic [BASE_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] RADIX_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] RADIX_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] LETTER_OFS = 6'd10;

  // parse phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_HEXPFX = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [END_W-1:0]   end_idx;
    logic               bad;
  } res_t;

  // digit value of a character, NO_DIGIT for anything else
  function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    diff = '0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      diff = c - CH_ZERO;
      return diff[BASE_W-1:0];
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      diff = c - CH_LA;
      return diff[BASE_W-1:0] + LETTER_OFS;
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      diff = c - CH_UA;
      return diff[BASE_W-1:0] + LETTER_OFS;
    end
    return NO_DIGIT;
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

endpackage

// ===== rtl/s2i_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// s2i_cfg_regs
// APB-style register slave holding the number base
// ---------------------------------------------------------------------------
module s2i_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [s2i_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [s2i_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [s2i_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [s2i_pkg::BASE_W-1:0]        number_base
);
  import s2i_pkg::*;

  logic [BASE_W-1:0] base_r;
  logic              reg_hit;
  logic              wr_en;

  // byte offset bits are ignored
  assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_NUMBER_BASE);
  assign wr_en   = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (wr_en) begin
      base_r <= pwdata[BASE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = CFG_DATA_W'(base_r);
    end
  end

  assign number_base = base_r;

endmodule

// ===== rtl/s2i_parse_unit.sv =====
// ---------------------------------------------------------------------------
// s2i_parse_unit
// Parse state and one-character step logic with multiply-accumulate
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module s2i_parse_unit #(
  parameter int unsigned INDEX_WIDTH = s2i_pkg::INDEX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [s2i_pkg::CHAR_W-1:0]    in_char,
  input  logic                          in_start,
  input  logic [s2i_pkg::BASE_W-1:0]    number_base,
  input  logic                          out_space,
  output logic                          step_go,
  output logic                          res_load,
  output s2i_pkg::res_t                 res
);
  import s2i_pkg::*;

  localparam logic [INDEX_WIDTH-1:0] IDX_MAX = {INDEX_WIDTH{1'b1}};

  logic [2:0]             phase_r, phase_nxt;
  logic [VALUE_W-1:0]     acc_r,   acc_nxt;
  logic                   neg_r,   neg_nxt;
  logic [BASE_W-1:0]      base_r,  base_nxt;
  logic [INDEX_WIDTH-1:0] idx_r,   idx_nxt;

  logic [2:0]             ph_e;
  logic [VALUE_W-1:0]     acc_e;
  logic                   neg_e;
  logic [BASE_W-1:0]      base_e;
  logic [INDEX_WIDTH-1:0] idx_e;

  logic [BASE_W-1:0]      dig;
  logic [BASE_W-1:0]      base_s;
  logic [BASE_W-1:0]      base_z;
  logic [VALUE_W-1:0]     mac;
  logic [VALUE_W-1:0]     sval;
  logic                   emit_raw;
  logic                   adv;
  logic                   sig_path;
  logic                   base_bad;

  function automatic logic [END_W-1:0] to_end(input logic [INDEX_WIDTH-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[END_W-1:0];
  endfunction

  assign dig      = digit_of(in_char);
  assign base_bad = (number_base == RADIX_ONE) || (number_base > MAX_RADIX);
  assign mac      = acc_r * VALUE_W'(base_r) + VALUE_W'(dig);
  assign sval     = neg_r ? (VALUE_W'(0) - acc_r) : acc_r;

  always_comb begin
    // a string start discards whatever was in progress
    if (in_start) begin
      ph_e   = base_bad ? PH_IDLE : PH_LEAD;
      acc_e  = '0;
      neg_e  = 1'b0;
      base_e = number_base;
      idx_e  = '0;
    end else begin
      ph_e   = phase_r;
      acc_e  = acc_r;
      neg_e  = neg_r;
      base_e = base_r;
      idx_e  = idx_r;
    end

    phase_nxt = in_start ? PH_LEAD : phase_r;
    acc_nxt   = acc_e;
    neg_nxt   = neg_e;
    base_nxt  = base_e;
    idx_nxt   = idx_e;
    emit_raw  = 1'b0;
    adv       = 1'b0;
    sig_path  = 1'b0;
    res       = '0;
    base_s    = (base_e == RADIX_AUTO) ? RADIX_DEC : base_e;
    base_z    = (base_e == RADIX_AUTO) ? RADIX_OCT : base_e;

    if (in_start && base_bad) begin
      emit_raw  = 1'b1;
      res.bad   = 1'b1;
      phase_nxt = PH_DONE;
    end

    case (ph_e)
      PH_LEAD: begin
        if (is_space(in_char)) begin
          adv = 1'b1;
        end else if (in_char == CH_PLUS) begin
          phase_nxt = PH_SIGNED;
          adv       = 1'b1;
        end else if (in_char == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGNED;
          adv       = 1'b1;
        end else begin
          sig_path = 1'b1;
        end
      end
      PH_SIGNED: begin
        sig_path = 1'b1;
      end
      PH_ZERO: begin
        if (in_char == CH_LX || in_char == CH_UX) begin
          base_nxt  = RADIX_HEX;
          phase_nxt = PH_HEXPFX;
          adv       = 1'b1;
        end else if (dig < base_z) begin
          // accumulator is still zero after the leading 0
          base_nxt  = base_z;
          acc_nxt   = VALUE_W'(dig);
          phase_nxt = PH_DIGITS;
          adv       = 1'b1;
        end else begin
          emit_raw    = 1'b1;
          res.end_idx = to_end(idx_e);
          phase_nxt   = PH_DONE;
        end
      end
      PH_HEXPFX: begin
        if (dig < RADIX_HEX) begin
          acc_nxt   = VALUE_W'(dig);
          phase_nxt = PH_DIGITS;
          adv       = 1'b1;
        end else begin
          // only the leading 0 counts as consumed
          emit_raw    = 1'b1;
          res.end_idx = to_end(idx_e - 1'b1);
          phase_nxt   = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (dig < base_e) begin
          acc_nxt = mac;
          adv     = 1'b1;
        end else begin
          emit_raw    = 1'b1;
          res.value   = sval;
          res.end_idx = to_end(idx_e);
          phase_nxt   = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // first significant character after whitespace and sign
    if (sig_path) begin
      if (in_char == CH_ZERO && (base_e == RADIX_AUTO || base_e == RADIX_HEX)) begin
        acc_nxt   = '0;
        phase_nxt = PH_ZERO;
        adv       = 1'b1;
      end else if (dig < base_s) begin
        base_nxt  = base_s;
        acc_nxt   = VALUE_W'(dig);
        phase_nxt = PH_DIGITS;
        adv       = 1'b1;
      end else begin
        base_nxt  = base_s;
        emit_raw  = 1'b1;
        phase_nxt = PH_DONE;
      end
    end

    if (adv && idx_e != IDX_MAX) begin
      idx_nxt = idx_e + 1'b1;
    end
  end

  assign step_go  = in_vld && (!emit_raw || out_space);
  assign res_load = step_go && emit_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      base_r  <= '0;
      idx_r   <= '0;
    end else if (step_go) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      base_r  <= base_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `S2I_ASSERT_IMPLY(a_bad_base_zero, clk, rst_n, res_load && res.bad, res.value == '0 && res.end_idx == '0)
  `S2I_ASSERT_IMPLY(a_load_has_space, clk, rst_n, res_load, out_space)
  `S2I_ASSERT_NEXT(a_done_after_result, clk, rst_n, res_load, phase_r == PH_DONE)
  `S2I_ASSERT_IMPLY(a_stray_char_silent, clk, rst_n, step_go && !in_start && (phase_r == PH_IDLE || phase_r == PH_DONE), !res_load)

endmodule

// ===== rtl/s2i_out_reg.sv =====
// ---------------------------------------------------------------------------
// s2i_out_reg
// Result holding register on the valid/ready output channel
// ---------------------------------------------------------------------------
module s2i_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  s2i_pkg::res_t res,
  input  logic          out_ready,
  output logic          space,
  output logic          out_valid,
  output s2i_pkg::res_t out_res
);
  import s2i_pkg::*;

  logic vld_r;
  res_t res_r;

  // room when empty or when the held transaction leaves this cycle
  assign space = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/string_to_integer_parser_core.sv =====
// ---------------------------------------------------------------------------
// string_to_integer_parser_core
// Streaming signed integer parser, one character per transaction
// ---------------------------------------------------------------------------
// Characters arrive on the in_ channel (valid/ready), in_string_start marking
// the first character of each string. At most one result per string leaves on
// the out_ channel: the signed value, the index of the first unused character
// and a flag for an invalid base. The base (2..36, 0 for auto-detect) is set
// through the cfg_ APB port and sampled at each string start.
// The character that ends the parse passes the input register, then
// the result register, whose load raises out_valid. Throughput: one character
// per cycle while no result waits for the output register; the step is a
// 64-bit by 6-bit multiply-accumulate between input register and parse state.
// Reset: base returns to 10, the parser goes idle and both registers empty.
// Stall: a held result does not block characters that give no result; the
// input stops only when a second result would need the output register.
// ---------------------------------------------------------------------------
module string_to_integer_parser_core #(
  parameter int unsigned INDEX_WIDTH = s2i_pkg::INDEX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [s2i_pkg::CHAR_W-1:0]      in_char_in,
  input  logic                            in_string_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [s2i_pkg::VALUE_W-1:0] out_parsed_value,
  output logic [s2i_pkg::END_W-1:0]       out_end_index,
  output logic                            out_base_invalid,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [s2i_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [s2i_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [s2i_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import s2i_pkg::*;

  logic              in_vld_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_start_r;
  logic [BASE_W-1:0] number_base;
  logic              step_go;
  logic              res_load;
  logic              out_space;
  res_t              res;
  res_t              out_res;

  assign in_ready = !in_vld_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r  <= in_char_in;
      in_start_r <= in_string_start;
    end
  end

  s2i_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .number_base (number_base)
  );

  s2i_parse_unit #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (in_vld_r),
    .in_char     (in_char_r),
    .in_start    (in_start_r),
    .number_base (number_base),
    .out_space   (out_space),
    .step_go     (step_go),
    .res_load    (res_load),
    .res         (res)
  );

  s2i_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res       (res),
    .out_ready (out_ready),
    .space     (out_space),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_parsed_value = out_res.value;
  assign out_end_index    = out_res.end_idx;
  assign out_base_invalid = out_res.bad;

endmodule
